>>> hdl/esc_pkg.sv
package esc_pkg;

  localparam int ADC_W   = 20;
  localparam int VAL_W   = 33;
  localparam int FUNC_W  = 2;
  localparam int STEP_W  = 4;
  localparam int APB_AW  = 6;
  localparam int APB_DW  = 64;
  localparam int DIV_CW  = 6;

  localparam logic [31:0] P_OFFSET  = 32'd64000;
  localparam logic [31:0] P_BASE    = 32'd1048576;
  localparam logic [31:0] P_SCALE   = 32'd3125;
  localparam logic [31:0] P_HALF    = 32'd32768;
  localparam logic [31:0] H_OFFSET  = 32'd76800;
  localparam logic [31:0] H_MAX     = 32'd419430400;
  localparam logic [31:0] H_BIAS    = 32'd2097152;
  localparam logic [31:0] H_ROUND   = 32'd16384;
  localparam logic [31:0] H_ROUND2  = 32'd8192;
  localparam logic [31:0] T_ROUND   = 32'd128;
  localparam logic [31:0] T_SCALE   = 32'd5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TEMP  = 2'd0,
    FUNC_PRESS = 2'd1,
    FUNC_HUM   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_CAL_TEMP    = 3'd0,
    REG_CAL_PRESS_A = 3'd1,
    REG_CAL_PRESS_B = 3'd2,
    REG_CAL_P9      = 3'd3,
    REG_CAL_HUM     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic              load;
    logic              exec;
    logic              ld_out;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic div_go;
    logic div_busy;
  } stat_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    asr = $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    sx16 = {{16{x[15]}}, x};
  endfunction

endpackage

>>> hdl/esc_if.sv
interface esc_in_if;
  import esc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [ADC_W-1:0]     adc_value;
  modport source (output valid, func, adc_value, input ready);
  modport sink   (input valid, func, adc_value, output ready);
endinterface

interface esc_out_if;
  import esc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    kind;
  logic signed [VAL_W-1:0] value;
  logic                 invalid;
  modport source (output valid, kind, value, invalid, input ready);
  modport sink   (input valid, kind, value, invalid, output ready);
endinterface

>>> hdl/esc_div.sv
module esc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  import esc_pkg::*;

  logic [31:0]       rem;
  logic [31:0]       dvs;
  logic [DIV_CW-1:0] cnt;
  logic [32:0]       rem_sh;
  logic [32:0]       diff;

  assign rem_sh = {rem, quotient[31]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CW'(31)) busy <= 1'b0;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem      <= diff[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= rem_sh[31:0];
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end
endmodule

>>> hdl/esc_datapath.sv
module esc_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  esc_pkg::cmd_t              cmd,
  output esc_pkg::stat_t             stat,
  input  logic [esc_pkg::FUNC_W-1:0] in_func,
  input  logic [esc_pkg::ADC_W-1:0]  in_adc,
  input  logic [47:0]                cal_temp,
  input  logic [63:0]                cal_press_a,
  input  logic [63:0]                cal_press_b,
  input  logic [15:0]                cal_press_p9,
  input  logic [63:0]                cal_hum,
  output logic [esc_pkg::FUNC_W-1:0] kind,
  output logic [esc_pkg::VAL_W-1:0]  value,
  output logic                       invalid
);
  import esc_pkg::*;

  func_t       fq;
  logic [ADC_W-1:0] adc;
  logic [31:0] r0, r1, r2, r3, r4, r5;
  logic [31:0] nr0, nr1, nr2, nr3, nr4, nr5;
  logic [31:0] fine_temperature, fine_temperature_next;
  logic        ft_we;
  logic [31:0] ma, mb, prod;
  logic [VAL_W-1:0] res_val;
  logic        res_bad;
  logic        div_start, div_busy;
  logic [31:0] div_q;
  logic [31:0] adc_u, adc16, tmp, hv;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'b0, cal_temp[15:0]};
  assign t2 = sx16(cal_temp[31:16]);
  assign t3 = sx16(cal_temp[47:32]);
  assign p1 = {16'b0, cal_press_a[15:0]};
  assign p2 = sx16(cal_press_a[31:16]);
  assign p3 = sx16(cal_press_a[47:32]);
  assign p4 = sx16(cal_press_a[63:48]);
  assign p5 = sx16(cal_press_b[15:0]);
  assign p6 = sx16(cal_press_b[31:16]);
  assign p7 = sx16(cal_press_b[47:32]);
  assign p8 = sx16(cal_press_b[63:48]);
  assign p9 = sx16(cal_press_p9);
  assign h1 = {24'b0, cal_hum[7:0]};
  assign h2 = sx16(cal_hum[23:8]);
  assign h3 = {24'b0, cal_hum[31:24]};
  assign h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
  assign h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
  assign h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};

  assign adc_u = {{(32-ADC_W){1'b0}}, adc};
  assign adc16 = {16'b0, adc[15:0]};

  // single shared multiplier, low 32 bits of the product
  assign prod = ma * mb;

  esc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (r5[31] ? r5 : {r5[30:0], 1'b0}),
    .divisor  (r4),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    ma = '0;
    mb = '0;
    nr0 = r0; nr1 = r1; nr2 = r2; nr3 = r3; nr4 = r4; nr5 = r5;
    fine_temperature_next = fine_temperature;
    ft_we   = 1'b0;
    res_val = '0;
    res_bad = 1'b0;
    stat.fin      = 1'b0;
    stat.div_go   = 1'b0;
    stat.div_busy = div_busy;
    tmp = '0;
    hv  = '0;
    case (fq)
      FUNC_TEMP: begin
        case (cmd.step)
          4'd0: nr0 = (adc_u >> 3) - (t1 << 1);
          4'd1: begin ma = r0; mb = t2; nr0 = asr(prod, 11); end
          4'd2: nr1 = (adc_u >> 4) - t1;
          4'd3: begin ma = r1; mb = r1; nr1 = asr(prod, 12); end
          4'd4: begin ma = r1; mb = t3; nr1 = asr(prod, 14); end
          4'd5: begin
            nr0 = r0 + r1;
            fine_temperature_next = r0 + r1;
            ft_we = 1'b1;
          end
          default: begin
            ma = r0; mb = T_SCALE;
            tmp = asr(prod + T_ROUND, 8);
            res_val = {tmp[31], tmp};
            stat.fin = 1'b1;
          end
        endcase
      end
      FUNC_PRESS: begin
        case (cmd.step)
          4'd0: begin
            tmp = asr(fine_temperature, 1) - P_OFFSET;
            nr0 = tmp;
            nr1 = asr(tmp, 2);
          end
          4'd1: begin ma = r1; mb = r1; nr2 = prod; end
          4'd2: begin ma = asr(r2, 11); mb = p6; nr3 = prod; end
          4'd3: begin ma = r0; mb = p5; nr3 = r3 + (prod << 1); end
          4'd4: nr3 = asr(r3, 2) + (p4 << 16);
          4'd5: begin ma = p3; mb = asr(r2, 13); nr4 = asr(prod, 3); end
          4'd6: begin ma = p2; mb = r0; nr4 = asr(r4 + asr(prod, 1), 18); end
          4'd7: begin ma = P_HALF + r4; mb = p1; nr4 = asr(prod, 15); end
          4'd8: begin
            if (r4 == '0) begin
              res_bad  = 1'b1;
              stat.fin = 1'b1;
            end else begin
              ma = (P_BASE - adc_u) - asr(r3, 12);
              mb = P_SCALE;
              nr5 = prod;
            end
          end
          4'd9: begin
            // remember whether the quotient must be doubled afterwards
            nr2 = {31'b0, r5[31]};
            stat.div_go = 1'b1;
          end
          4'd10: nr5 = r2[0] ? {div_q[30:0], 1'b0} : div_q;
          4'd11: begin ma = r5 >> 3; mb = r5 >> 3; nr0 = prod >> 13; end
          4'd12: begin ma = p9; mb = r0; nr0 = asr(prod, 12); end
          4'd13: begin ma = r5 >> 2; mb = p8; nr1 = asr(prod, 13); end
          default: begin
            tmp = r5 + asr(r0 + r1 + p7, 4);
            res_val = {1'b0, tmp};
            stat.fin = 1'b1;
          end
        endcase
      end
      FUNC_HUM: begin
        case (cmd.step)
          4'd0: nr0 = fine_temperature - H_OFFSET;
          4'd1: begin ma = r0; mb = h5; nr1 = prod; end
          4'd2: nr1 = asr((adc16 << 14) - (h4 << 20) - r1 + H_ROUND, 15);
          4'd3: begin ma = r0; mb = h6; nr2 = asr(prod, 10); end
          4'd4: begin ma = r0; mb = h3; nr3 = asr(prod, 11) + P_HALF; end
          4'd5: begin ma = r2; mb = r3; nr2 = prod; end
          4'd6: nr2 = asr(r2, 10) + H_BIAS;
          4'd7: begin ma = r2; mb = h2; nr2 = asr(prod + H_ROUND2, 14); end
          4'd8: begin ma = r1; mb = r2; nr1 = prod; end
          4'd9: begin ma = asr(r1, 15); mb = asr(r1, 15); nr2 = prod; end
          4'd10: begin ma = asr(r2, 7); mb = h1; nr2 = prod; end
          4'd11: nr1 = r1 - asr(r2, 4);
          default: begin
            hv = r1;
            if (hv[31]) hv = '0;
            if (hv > H_MAX) hv = H_MAX;
            res_val = {1'b0, hv >> 12};
            stat.fin = 1'b1;
          end
        endcase
      end
      default: begin
        res_bad  = 1'b1;
        stat.fin = 1'b1;
      end
    endcase
  end

  assign div_start = cmd.exec && stat.div_go;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fq  <= func_t'(in_func);
      adc <= in_adc;
    end
    if (cmd.exec) begin
      r0 <= nr0; r1 <= nr1; r2 <= nr2; r3 <= nr3; r4 <= nr4; r5 <= nr5;
    end
    if (cmd.ld_out) begin
      kind    <= fq;
      value   <= res_val;
      invalid <= res_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fine_temperature <= '0;
    end else if (cmd.exec && ft_we) begin
      fine_temperature <= fine_temperature_next;
    end
  end
endmodule

>>> hdl/esc_ctrl.sv
module esc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output esc_pkg::cmd_t  cmd,
  input  esc_pkg::stat_t stat
);
  import esc_pkg::*;

  state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    cmd.ld_out = 1'b0;
    cmd.step   = step;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.div_go) begin
          cmd.exec   = 1'b1;
          step_next  = step + 1'b1;
          state_next = ST_DIV;
        end else if (stat.fin) begin
          // hold the final step until the output register is free
          if (out_free) begin
            cmd.ld_out = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.exec  = 1'b1;
          step_next = step + 1'b1;
        end
      end
      ST_DIV: begin
        if (!stat.div_busy) state_next = ST_RUN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule

>>> hdl/env_sensor_compensation_top.sv
// channel  dir  handshake       payload
// in_ch    in   valid / ready   func[1:0], adc_value[19:0]
// out_ch   out  valid / ready   kind[1:0], value[32:0], invalid
// apb      in   psel / penable  paddr[5:0], pwdata[63:0], prdata[63:0]
//
// one transaction at a time through a shared 32x32 multiplier sequencer
// temperature, humidity and pressure each run as a sequence of steps; pressure
// takes 15 steps and waits on the radix-2 divider; an unused selector is reported invalid
// reset is synchronous and clears the calibration registers and fine temperature
// a finished result waits in the output register while the next input is taken
module env_sensor_compensation_top (
  input  logic                       clk,
  input  logic                       rst,
  esc_in_if.sink                     in_ch,
  esc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [esc_pkg::APB_AW-1:0] paddr,
  input  logic [esc_pkg::APB_DW-1:0] pwdata,
  output logic [esc_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import esc_pkg::*;

  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [15:0] cal_press_p9;
  logic [63:0] cal_hum;
  reg_idx_t    ridx;
  cmd_t        cmd;
  stat_t       stat;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp     <= '0;
      cal_press_a  <= '0;
      cal_press_b  <= '0;
      cal_press_p9 <= '0;
      cal_hum      <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_CAL_TEMP:    cal_temp     <= pwdata[47:0];
        REG_CAL_PRESS_A: cal_press_a  <= pwdata;
        REG_CAL_PRESS_B: cal_press_b  <= pwdata;
        REG_CAL_P9:      cal_press_p9 <= pwdata[15:0];
        REG_CAL_HUM:     cal_hum      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_CAL_TEMP:    prdata = {16'b0, cal_temp};
      REG_CAL_PRESS_A: prdata = cal_press_a;
      REG_CAL_PRESS_B: prdata = cal_press_b;
      REG_CAL_P9:      prdata = {48'b0, cal_press_p9};
      REG_CAL_HUM:     prdata = cal_hum;
      default:         prdata = '0;
    endcase
  end

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  esc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (in_ch.func),
    .in_adc       (in_ch.adc_value),
    .cal_temp     (cal_temp),
    .cal_press_a  (cal_press_a),
    .cal_press_b  (cal_press_b),
    .cal_press_p9 (cal_press_p9),
    .cal_hum      (cal_hum),
    .kind         (out_ch.kind),
    .value        (out_ch.value),
    .invalid      (out_ch.invalid)
  );
endmodule

>>> hdl/esc_checker.sv
module esc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [esc_pkg::FUNC_W-1:0] kind,
  input logic [esc_pkg::VAL_W-1:0]  value,
  input logic                       invalid
);
  import esc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_none_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == FUNC_NONE |-> invalid && value == '0)
    else $error("unused selector must report invalid zero");

  a_ok_kinds: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == FUNC_TEMP || kind == FUNC_HUM) |-> !invalid)
    else $error("invalid set on temperature or humidity");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> value == '0)
    else $error("invalid result with nonzero value");
endmodule

bind env_sensor_compensation_top esc_checker u_esc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .value     (out_ch.value),
  .invalid   (out_ch.invalid)
);
